[rtl/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/apsh_pkg.sv]
// ----------------------------------------------------------------------------
// apsh_pkg
// types, codes and helpers for the ata pio lba28 host sequencer
// ----------------------------------------------------------------------------
package apsh_pkg;

   localparam int SECTOR_WORDS = 256;
   localparam int WORD_W       = $clog2(SECTOR_WORDS + 1);
   localparam int POLL_W       = 17;
   localparam int LBA_W        = 28;
   localparam int DATA_W       = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int BURST_MAX    = 6;
   localparam int CNT_W        = 3;
   localparam int QDEPTH       = 8;
   localparam int PTR_W        = 3;
   localparam int COUNT_W      = 4;

   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 17'd100000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POLL_LIMIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_SELECT = 1'b1;

   // request codes
   localparam logic [2:0] REQ_PROBE = 3'd0;
   localparam logic [2:0] REQ_READ  = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_RESP  = 3'd3;
   localparam logic [2:0] REQ_WDATA = 3'd4;

   // operation kinds held during a request
   localparam logic [1:0] OP_PROBE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_BUS  = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_WREQ = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // completion causes
   localparam logic [2:0] CAUSE_NONE        = 3'd0;
   localparam logic [2:0] CAUSE_NO_DEVICE   = 3'd1;
   localparam logic [2:0] CAUSE_NOT_ATA     = 3'd2;
   localparam logic [2:0] CAUSE_DEV_ERROR   = 3'd3;
   localparam logic [2:0] CAUSE_TIMEOUT     = 3'd4;
   localparam logic [2:0] CAUSE_NOT_PRESENT = 3'd5;

   // task-file offsets
   localparam logic [2:0] PORT_DATA   = 3'd0;
   localparam logic [2:0] PORT_COUNT  = 3'd2;
   localparam logic [2:0] PORT_LBA_LO = 3'd3;
   localparam logic [2:0] PORT_LBA_MD = 3'd4;
   localparam logic [2:0] PORT_LBA_HI = 3'd5;
   localparam logic [2:0] PORT_DEVSEL = 3'd6;
   localparam logic [2:0] PORT_STATUS = 3'd7;

   // ata commands and bytes
   localparam logic [7:0] ATA_READ     = 8'h20;
   localparam logic [7:0] ATA_WRITE    = 8'h30;
   localparam logic [7:0] ATA_FLUSH    = 8'hE7;
   localparam logic [7:0] ATA_IDENTIFY = 8'hEC;
   localparam logic [7:0] SEL_LBA      = 8'hE0;
   localparam logic [7:0] SEL_PROBE    = 8'hA0;

   // status bits
   localparam int ST_BSY = 7;
   localparam int ST_DRQ = 3;
   localparam int ST_ERR = 0;

   typedef enum logic [12:0] {
      PH_IDLE     = 13'h0001,
      PH_ID_DELAY = 13'h0002,
      PH_ID_STAT  = 13'h0004,
      PH_ID_BSY   = 13'h0008,
      PH_ID_MID   = 13'h0010,
      PH_ID_HI    = 13'h0020,
      PH_DRQ      = 13'h0040,
      PH_DATA     = 13'h0080,
      PH_RW_BSY1  = 13'h0100,
      PH_RW_DELAY = 13'h0200,
      PH_RW_BSY2  = 13'h0400,
      PH_WR_WORD  = 13'h0800,
      PH_WR_FLUSH = 13'h1000
   } phase_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              bus_write;
      logic              bus_wide;
      logic [2:0]        port_offset;
      logic [DATA_W-1:0] bus_data;
      logic              ok;
      logic [2:0]        fail_cause;
      logic              last;
   } res_type;

   typedef struct packed {
      logic [CNT_W-1:0]            cnt;
      res_type [BURST_MAX-1:0]     res;
   } burst_type;

   // req_tdata layout, low bits first: lba, data_in, zero fill
   typedef struct packed {
      logic [3:0]        pad;
      logic [DATA_W-1:0] data_in;
      logic [LBA_W-1:0]  lba;
   } req_data_type;

   // rsp_tdata layout, low bits first
   typedef struct packed {
      logic [6:0]        pad;
      logic [2:0]        fail_cause;
      logic              ok;
      logic [DATA_W-1:0] bus_data;
      logic [2:0]        port_offset;
      logic              bus_wide;
      logic              bus_write;
   } rsp_data_type;

   function automatic res_type res_byte(logic [2:0] port, logic [7:0] value);
      res_type r;
      r = '0;
      r.kind        = KIND_BUS;
      r.bus_write   = 1'b1;
      r.port_offset = port;
      r.bus_data    = {8'h00, value};
      return r;
   endfunction

   function automatic res_type res_read(logic [2:0] port, logic wide);
      res_type r;
      r = '0;
      r.kind        = KIND_BUS;
      r.bus_wide    = wide;
      r.port_offset = port;
      return r;
   endfunction

   function automatic res_type res_done(logic ok, logic [2:0] cause);
      res_type r;
      r = '0;
      r.kind       = KIND_DONE;
      r.ok         = ok;
      r.fail_cause = cause;
      return r;
   endfunction

   function automatic res_type res_kind(logic [1:0] kind, logic [DATA_W-1:0] value);
      res_type r;
      r = '0;
      r.kind     = kind;
      r.bus_data = value;
      return r;
   endfunction

endpackage

[rtl/apsh_ctrl.sv]
// ----------------------------------------------------------------------------
// apsh_ctrl
// sequencer state, config registers and the result burst of each item
// ----------------------------------------------------------------------------
module apsh_ctrl
   import apsh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [POLL_W-1:0]     csr_wdata,
   input  logic                  accept,
   input  logic [2:0]            command,
   input  logic [LBA_W-1:0]      lba,
   input  logic [DATA_W-1:0]     data_in,
   output burst_type             burst
);

   logic [POLL_W-1:0] poll_limit_ff;
   logic              drive_ff;
   phase_type         phase_ff, phase_in;
   logic [1:0]        op_ff, op_in;
   logic [LBA_W-1:0]  lba_ff, lba_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [POLL_W-1:0] poll_ff, poll_in;
   logic [1:0]        delay_ff, delay_in;
   logic              present_ff, present_in;

   logic [POLL_W-1:0] lim;
   logic [POLL_W-1:0] poll_next;
   logic [WORD_W-1:0] word_next;
   logic              word_done;
   logic [7:0]        st;
   logic              busy_again;
   logic              is_request;
   burst_type         b;

   assign lim        = (poll_limit_ff == '0) ? POLL_W'(1) : poll_limit_ff;
   assign poll_next  = poll_ff + POLL_W'(1);
   assign word_next  = word_ff + WORD_W'(1);
   assign word_done  = word_next >= WORD_W'(SECTOR_WORDS);
   assign st         = data_in[7:0];
   assign busy_again = st[ST_BSY] && (poll_next < lim);
   assign is_request = (command == REQ_PROBE) || (command == REQ_READ) ||
                       (command == REQ_WRITE);

   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      lba_in     = lba_ff;
      word_in    = word_ff;
      poll_in    = poll_ff;
      delay_in   = delay_ff;
      present_in = present_ff;
      b          = '0;
      if (accept) begin
         priority if (is_request) begin
            if (phase_ff == PH_IDLE) begin
               op_in = command[1:0];
               if (command == REQ_PROBE) begin
                  present_in = 1'b0;
                  b.res[0]   = res_byte(PORT_DEVSEL, SEL_PROBE | {3'b000, drive_ff, 4'h0});
                  b.res[1]   = res_read(PORT_STATUS, 1'b0);
                  b.cnt      = 3'd2;
                  delay_in   = '0;
                  phase_in   = PH_ID_DELAY;
               end else if (!present_ff) begin
                  b.res[0] = res_done(1'b0, CAUSE_NOT_PRESENT);
                  b.cnt    = 3'd1;
               end else begin
                  lba_in   = lba;
                  poll_in  = '0;
                  b.res[0] = res_read(PORT_STATUS, 1'b0);
                  b.cnt    = 3'd1;
                  phase_in = PH_RW_BSY1;
               end
            end
         end else if (command == REQ_RESP) begin
            unique case (phase_ff)
               PH_ID_DELAY, PH_RW_DELAY: begin
                  if (delay_ff != 2'd3) begin
                     delay_in = delay_ff + 2'd1;
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                     b.cnt    = 3'd1;
                  end else if (phase_ff == PH_RW_DELAY) begin
                     b.res[0] = res_byte(PORT_COUNT, 8'h01);
                     b.res[1] = res_byte(PORT_LBA_LO, lba_ff[7:0]);
                     b.res[2] = res_byte(PORT_LBA_MD, lba_ff[15:8]);
                     b.res[3] = res_byte(PORT_LBA_HI, lba_ff[23:16]);
                     b.res[4] = res_byte(PORT_STATUS,
                                         (op_ff == OP_WRITE) ? ATA_WRITE : ATA_READ);
                     b.res[5] = res_read(PORT_STATUS, 1'b0);
                     b.cnt    = 3'd6;
                     poll_in  = '0;
                     phase_in = PH_RW_BSY2;
                  end else begin
                     b.res[0] = res_byte(PORT_COUNT, 8'h00);
                     b.res[1] = res_byte(PORT_LBA_LO, 8'h00);
                     b.res[2] = res_byte(PORT_LBA_MD, 8'h00);
                     b.res[3] = res_byte(PORT_LBA_HI, 8'h00);
                     b.res[4] = res_byte(PORT_STATUS, ATA_IDENTIFY);
                     b.res[5] = res_read(PORT_STATUS, 1'b0);
                     b.cnt    = 3'd6;
                     phase_in = PH_ID_STAT;
                  end
               end
               PH_ID_STAT: begin
                  b.cnt = 3'd1;
                  if (st == 8'h00) begin
                     b.res[0] = res_done(1'b0, CAUSE_NO_DEVICE);
                     phase_in = PH_IDLE;
                  end else begin
                     poll_in  = '0;
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                     phase_in = PH_ID_BSY;
                  end
               end
               PH_ID_BSY: begin
                  poll_in = poll_next;
                  b.cnt   = 3'd1;
                  if (busy_again) begin
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                  end else begin
                     b.res[0] = res_read(PORT_LBA_MD, 1'b0);
                     phase_in = PH_ID_MID;
                  end
               end
               PH_ID_MID, PH_ID_HI: begin
                  b.cnt = 3'd1;
                  if (st != 8'h00) begin
                     b.res[0] = res_done(1'b0, CAUSE_NOT_ATA);
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_ID_MID) begin
                     b.res[0] = res_read(PORT_LBA_HI, 1'b0);
                     phase_in = PH_ID_HI;
                  end else begin
                     poll_in  = '0;
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                     phase_in = PH_DRQ;
                  end
               end
               PH_DRQ: begin
                  poll_in = poll_next;
                  b.cnt   = 3'd1;
                  priority if (st[ST_ERR]) begin
                     b.res[0] = res_done(1'b0, CAUSE_DEV_ERROR);
                     phase_in = PH_IDLE;
                  end else if (st[ST_DRQ]) begin
                     word_in = '0;
                     if (op_ff == OP_WRITE) begin
                        b.res[0] = res_kind(KIND_WREQ, '0);
                        phase_in = PH_WR_WORD;
                     end else begin
                        b.res[0] = res_read(PORT_DATA, 1'b1);
                        phase_in = PH_DATA;
                     end
                  end else if (poll_next >= lim) begin
                     b.res[0] = res_done(1'b0, CAUSE_TIMEOUT);
                     phase_in = PH_IDLE;
                  end else begin
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                  end
               end
               PH_DATA: begin
                  word_in = word_next;
                  if (op_ff == OP_READ) begin
                     b.res[0] = res_kind(KIND_WORD, data_in);
                     b.res[1] = word_done ? res_done(1'b1, CAUSE_NONE)
                                          : res_read(PORT_DATA, 1'b1);
                     b.cnt    = 3'd2;
                  end else begin
                     b.res[0] = word_done ? res_done(1'b1, CAUSE_NONE)
                                          : res_read(PORT_DATA, 1'b1);
                     b.cnt    = 3'd1;
                  end
                  if (word_done) begin
                     if (op_ff == OP_PROBE) present_in = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               PH_RW_BSY1: begin
                  poll_in = poll_next;
                  if (busy_again) begin
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                     b.cnt    = 3'd1;
                  end else begin
                     b.res[0] = res_byte(PORT_DEVSEL,
                                         SEL_LBA | {3'b000, drive_ff, lba_ff[27:24]});
                     b.res[1] = res_read(PORT_STATUS, 1'b0);
                     b.cnt    = 3'd2;
                     delay_in = '0;
                     phase_in = PH_RW_DELAY;
                  end
               end
               PH_RW_BSY2: begin
                  b.res[0] = res_read(PORT_STATUS, 1'b0);
                  b.cnt    = 3'd1;
                  if (busy_again) begin
                     poll_in  = poll_next;
                  end else begin
                     poll_in  = '0;
                     phase_in = PH_DRQ;
                  end
               end
               PH_WR_FLUSH: begin
                  poll_in = poll_next;
                  b.cnt   = 3'd1;
                  if (busy_again) begin
                     b.res[0] = res_read(PORT_STATUS, 1'b0);
                  end else begin
                     b.res[0] = res_done(1'b1, CAUSE_NONE);
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end else if (command == REQ_WDATA) begin
            if (phase_ff == PH_WR_WORD) begin
               word_in           = word_next;
               b.res[0]          = res_kind(KIND_BUS, data_in);
               b.res[0].bus_write = 1'b1;
               b.res[0].bus_wide  = 1'b1;
               if (word_done) begin
                  b.res[1] = res_byte(PORT_STATUS, ATA_FLUSH);
                  b.res[2] = res_read(PORT_STATUS, 1'b0);
                  b.cnt    = 3'd3;
                  poll_in  = '0;
                  phase_in = PH_WR_FLUSH;
               end else begin
                  b.res[1] = res_kind(KIND_WREQ, '0);
                  b.cnt    = 3'd2;
               end
            end
         end else begin
         end
      end
   end

   always_comb begin
      burst = b;
      for (int i = 0; i < BURST_MAX; i++) begin
         burst.res[i].last = (CNT_W'(i + 1) == b.cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
         drive_ff      <= 1'b1;
         phase_ff      <= PH_IDLE;
         op_ff         <= '0;
         lba_ff        <= '0;
         word_ff       <= '0;
         poll_ff       <= '0;
         delay_ff      <= '0;
         present_ff    <= 1'b0;
      end else begin
         if (csr_we && csr_addr == REG_POLL_LIMIT) poll_limit_ff <= csr_wdata;
         if (csr_we && csr_addr == REG_DRIVE_SELECT) drive_ff <= csr_wdata[0];
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         lba_ff     <= lba_in;
         word_ff    <= word_in;
         poll_ff    <= poll_in;
         delay_ff   <= delay_in;
         present_ff <= present_in;
      end
   end

endmodule

[rtl/apsh_rsp_queue.sv]
// ----------------------------------------------------------------------------
// apsh_rsp_queue
// result queue: takes up to six results a burst, gives one per pop_ready cycle
// ----------------------------------------------------------------------------
module apsh_rsp_queue
   import apsh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type burst,
   input  logic      pop_ready,
   output logic      out_valid,
   output res_type   out_res,
   output logic      room
);

   res_type              queue_ff [QDEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]     push_cnt;
   logic                 pop;

   assign push_cnt  = push ? burst.cnt : '0;
   assign out_valid = count_ff != '0;
   assign out_res   = queue_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;
   assign room      = count_ff <= COUNT_W'(QDEPTH - BURST_MAX);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + COUNT_W'(push_cnt) - COUNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int j = 0; j < BURST_MAX; j++) begin
         if (CNT_W'(j) < push_cnt) queue_ff[wr_ptr_ff + PTR_W'(j)] <= burst.res[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ata_pio_sector_host_sequencer_top.sv]
// ----------------------------------------------------------------------------
// ata_pio_sector_host_sequencer_top
// ata pio lba28 host sequencer: requests and bus responses in, task-file
// accesses, sector words, data requests and completions out
// ----------------------------------------------------------------------------
// the results of an accepted item are registered in the queue before they are offered
// an item gives 0 to 6 results, delivered one per cycle from an 8-entry queue while
// rsp_tready is high; req_tready is high while at most 2 results wait, so 1 item
// per cycle when items give one result each and the result side keeps up
// reset clears the sequence to idle, drops the drive-found flag and empties
// the queue; poll_limit returns to 100000 and drive_select to 1
module ata_pio_sector_host_sequencer_top
   import apsh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [POLL_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // lba, data_in, zero fill
   input  logic [2:0]           req_tuser,   // command
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // bus_write, bus_wide, port_offset,
                                             // bus_data, ok, fail_cause, zero fill
   output logic [1:0]           rsp_tuser,   // kind
   output logic                 rsp_tlast
);

   req_data_type req_d;
   rsp_data_type rsp_d;
   burst_type    burst;
   res_type      res;
   logic         accept;

   assign req_d  = req_data_type'(req_tdata);
   assign accept = req_tvalid && req_tready;

   apsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .command   (req_tuser),
      .lba       (req_d.lba),
      .data_in   (req_d.data_in),
      .burst     (burst)
   );

   apsh_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .burst     (burst),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_res   (res),
      .room      (req_tready)
   );

   always_comb begin
      rsp_d             = '0;
      rsp_d.bus_write   = res.bus_write;
      rsp_d.bus_wide    = res.bus_wide;
      rsp_d.port_offset = res.port_offset;
      rsp_d.bus_data    = res.bus_data;
      rsp_d.ok          = res.ok;
      rsp_d.fail_cause  = res.fail_cause;
   end

   assign rsp_tdata = rsp_d;
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

[rtl/apsh_checker.sv]
// ----------------------------------------------------------------------------
// apsh_checker
// port-level checks on the sequencer result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsh_checker
   import apsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast
);

   rsp_data_type rsp_d;

   assign rsp_d = rsp_data_type'(rsp_tdata);

   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result offered right after reset")
   `ASSERT_CLK(a_done_last, rsp_tvalid && rsp_tuser == KIND_DONE |-> rsp_tlast, "completion not last of its item")
   `ASSERT_CLK(a_word_not_last, rsp_tvalid && rsp_tuser == KIND_BUS && rsp_d.bus_write && rsp_d.bus_wide |-> !rsp_tlast, "data word write ended an item")

endmodule

bind ata_pio_sector_host_sequencer_top apsh_checker u_apsh_checker (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ATA PIO LBA28 host sequencer. A short table of
// directed items covers the failures that end a request early: no drive found,
// no device, not ATA, ignored items. A device model then answers every bus
// read from the live sequencer state (busy, DRQ, ERR, polling timeouts, one
// full sector transfer early in the run) with random noise mixed in. Each
// accepted item goes through a behavioral predictor. Every result is compared
// field by field with the oldest expected one. Both handshakes stall at
// random, and the poll limit and drive select change between phases.
// ----------------------------------------------------------------------------
module testbench;
   import apsh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam int ITEM_BUDGET  = 350;
   localparam int PHASE_MIN    = 20;
   localparam int GRANT_BEFORE = 60;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NOTHING,
      CHK_DONE
   } row_check_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [LBA_W-1:0]  lba;
      logic [DATA_W-1:0] data;
      row_check_type     check;
      res_type           res;
   } dir_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = '0;
   logic [POLL_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata  = '0;
   logic [2:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tlast;

   ata_pio_sector_host_sequencer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   logic [POLL_W-1:0] cfg_poll_limit = POLL_LIMIT_RESET;
   logic              cfg_drive      = 1'b1;
   phase_type         seq_phase      = PH_IDLE;
   logic [1:0]        op_held        = OP_PROBE;
   logic [LBA_W-1:0]  lba_held       = '0;
   int unsigned       words_done     = 0;
   int unsigned       polls          = 0;
   int unsigned       delay_cnt      = 0;
   logic              drive_found    = 1'b0;

   res_type     due_results[$];
   dir_row_type dir_table[$];
   int          errors        = 0;
   int          send_idle_pct = 17;
   int          recv_idle_pct = 47;
   int          sent_items    = 0;
   int          data_grants   = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic res_type done_res(logic ok, logic [2:0] cause);
      res_type r;
      r            = '0;
      r.kind       = KIND_DONE;
      r.ok         = ok;
      r.fail_cause = cause;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic void add_result(logic [1:0] kind, logic wr, logic wide,
                                      logic [2:0] port, logic [DATA_W-1:0] value);
      res_type r;
      r             = '0;
      r.kind        = kind;
      r.bus_write   = wr;
      r.bus_wide    = wide;
      r.port_offset = port;
      r.bus_data    = value;
      due_results.push_back(r);
   endfunction

   function automatic void add_byte(logic [2:0] port, logic [7:0] value);
      add_result(KIND_BUS, 1'b1, 1'b0, port, {8'h00, value});
   endfunction

   function automatic void add_read(phase_type ph, logic [2:0] port, logic wide);
      seq_phase = ph;
      add_result(KIND_BUS, 1'b0, wide, port, '0);
   endfunction

   function automatic void add_done(logic ok, logic [2:0] cause);
      due_results.push_back(done_res(ok, cause));
      seq_phase = PH_IDLE;
   endfunction

   function automatic int unsigned eff_limit();
      return (cfg_poll_limit == '0) ? 1 : 32'(cfg_poll_limit);
   endfunction

   function automatic void begin_wait(phase_type ph);
      polls = 0;
      add_read(ph, PORT_STATUS, 1'b0);
   endfunction

   // counts one poll, true while the drive stays busy and polls remain
   function automatic bit busy_repeat(logic [7:0] st);
      polls++;
      return st[ST_BSY] && (polls < eff_limit());
   endfunction

   function automatic void rw_select();
      add_byte(PORT_DEVSEL, SEL_LBA | {3'b000, cfg_drive, 4'h0} | {4'h0, lba_held[27:24]});
      delay_cnt = 0;
      add_read(PH_RW_DELAY, PORT_STATUS, 1'b0);
   endfunction

   function automatic void issue_rw();
      add_byte(PORT_COUNT, 8'h01);
      add_byte(PORT_LBA_LO, lba_held[7:0]);
      add_byte(PORT_LBA_MD, lba_held[15:8]);
      add_byte(PORT_LBA_HI, lba_held[23:16]);
      add_byte(PORT_STATUS, (op_held == OP_WRITE) ? ATA_WRITE : ATA_READ);
      begin_wait(PH_RW_BSY2);
   endfunction

   function automatic void drq_ready();
      words_done = 0;
      if (op_held == OP_WRITE) begin
         seq_phase = PH_WR_WORD;
         add_result(KIND_WREQ, 1'b0, 1'b0, '0, '0);
      end else begin
         add_read(PH_DATA, PORT_DATA, 1'b1);
      end
   endfunction

   function automatic void take_response(logic [DATA_W-1:0] v);
      logic [7:0] st;
      st = v[7:0];
      case (seq_phase)
         PH_ID_DELAY, PH_RW_DELAY: begin
            if (delay_cnt < 3) begin
               delay_cnt++;
               add_read(seq_phase, PORT_STATUS, 1'b0);
            end else if (seq_phase == PH_RW_DELAY) begin
               issue_rw();
            end else begin
               add_byte(PORT_COUNT, 8'h00);
               add_byte(PORT_LBA_LO, 8'h00);
               add_byte(PORT_LBA_MD, 8'h00);
               add_byte(PORT_LBA_HI, 8'h00);
               add_byte(PORT_STATUS, ATA_IDENTIFY);
               add_read(PH_ID_STAT, PORT_STATUS, 1'b0);
            end
         end
         PH_ID_STAT: begin
            if (st == 8'h00) add_done(1'b0, CAUSE_NO_DEVICE);
            else begin_wait(PH_ID_BSY);
         end
         PH_ID_BSY: begin
            if (busy_repeat(st)) add_read(PH_ID_BSY, PORT_STATUS, 1'b0);
            else add_read(PH_ID_MID, PORT_LBA_MD, 1'b0);
         end
         PH_ID_MID: begin
            if (st != 8'h00) add_done(1'b0, CAUSE_NOT_ATA);
            else add_read(PH_ID_HI, PORT_LBA_HI, 1'b0);
         end
         PH_ID_HI: begin
            if (st != 8'h00) add_done(1'b0, CAUSE_NOT_ATA);
            else begin_wait(PH_DRQ);
         end
         PH_DRQ: begin
            polls++;
            if (st[ST_ERR]) add_done(1'b0, CAUSE_DEV_ERROR);
            else if (st[ST_DRQ]) drq_ready();
            else if (polls >= eff_limit()) add_done(1'b0, CAUSE_TIMEOUT);
            else add_read(PH_DRQ, PORT_STATUS, 1'b0);
         end
         PH_DATA: begin
            if (op_held == OP_READ) add_result(KIND_WORD, 1'b0, 1'b0, '0, v);
            words_done++;
            if (words_done >= SECTOR_WORDS) begin
               if (op_held == OP_PROBE) drive_found = 1'b1;
               add_done(1'b1, CAUSE_NONE);
            end else begin
               add_read(PH_DATA, PORT_DATA, 1'b1);
            end
         end
         PH_RW_BSY1: begin
            if (busy_repeat(st)) add_read(PH_RW_BSY1, PORT_STATUS, 1'b0);
            else rw_select();
         end
         PH_RW_BSY2: begin
            if (busy_repeat(st)) add_read(PH_RW_BSY2, PORT_STATUS, 1'b0);
            else begin_wait(PH_DRQ);
         end
         PH_WR_FLUSH: begin
            if (busy_repeat(st)) add_read(PH_WR_FLUSH, PORT_STATUS, 1'b0);
            else add_done(1'b1, CAUSE_NONE);
         end
         default: ;
      endcase
   endfunction

   // returns how many results the item adds
   function automatic int predict_sequencer(logic [2:0] cmd, logic [LBA_W-1:0] lba,
                                            logic [DATA_W-1:0] data);
      int n0;
      n0 = due_results.size();
      if (cmd <= REQ_WRITE) begin
         if (seq_phase == PH_IDLE) begin
            op_held = cmd[1:0];
            if (cmd == REQ_PROBE) begin
               drive_found = 1'b0;
               add_byte(PORT_DEVSEL, SEL_PROBE | {3'b000, cfg_drive, 4'h0});
               delay_cnt = 0;
               add_read(PH_ID_DELAY, PORT_STATUS, 1'b0);
            end else if (!drive_found) begin
               add_done(1'b0, CAUSE_NOT_PRESENT);
            end else begin
               lba_held = lba;
               begin_wait(PH_RW_BSY1);
            end
         end
      end else if (cmd == REQ_RESP) begin
         if (seq_phase != PH_IDLE && seq_phase != PH_WR_WORD) take_response(data);
      end else if (cmd == REQ_WDATA) begin
         if (seq_phase == PH_WR_WORD) begin
            add_result(KIND_BUS, 1'b1, 1'b1, PORT_DATA, data);
            words_done++;
            if (words_done >= SECTOR_WORDS) begin
               add_byte(PORT_STATUS, ATA_FLUSH);
               begin_wait(PH_WR_FLUSH);
            end else begin
               add_result(KIND_WREQ, 1'b0, 1'b0, '0, '0);
            end
         end
      end
      if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
      return due_results.size() - n0;
   endfunction

   function automatic dir_row_type dir_step(logic [2:0] cmd, logic [LBA_W-1:0] lba,
                                            logic [DATA_W-1:0] data, row_check_type check,
                                            res_type res);
      dir_row_type r;
      r.cmd   = cmd;
      r.lba   = lba;
      r.data  = data;
      r.check = check;
      r.res   = res;
      return r;
   endfunction

   task automatic send_item(input logic [2:0] cmd, input logic [LBA_W-1:0] lba,
                            input logic [DATA_W-1:0] data, output int added);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'h0, data, lba};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      added = predict_sequencer(cmd, lba, data);
   endtask

   task automatic set_config(input logic [POLL_W-1:0] poll_max, input logic drv);
      csr_we    <= 1'b1;
      csr_addr  <= REG_POLL_LIMIT;
      csr_wdata <= poll_max;
      @(posedge clock);
      cfg_poll_limit = poll_max;
      csr_addr  <= REG_DRIVE_SELECT;
      csr_wdata <= {16'h0000, drv};
      @(posedge clock);
      cfg_drive = drv;
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input logic [POLL_W-1:0] poll_max, input logic drv,
                            input int item_goal);
      int counted, added, roll;
      logic [2:0]        cmd;
      logic [LBA_W-1:0]  lba;
      logic [DATA_W-1:0] data;
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      set_config(poll_max, drv);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      counted = 0;
      while (counted < PHASE_MIN || sent_items < item_goal || seq_phase != PH_IDLE) begin
         lba  = LBA_W'($urandom);
         data = DATA_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            // noise the sequencer must ignore in its present state
            roll = $urandom_range(0, 2);
            if (roll == 0) cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            else if (seq_phase == PH_IDLE) cmd = (roll == 1) ? REQ_RESP : REQ_WDATA;
            else if (seq_phase == PH_WR_WORD)
               cmd = (roll == 1) ? REQ_RESP : 3'($urandom_range(REQ_PROBE, REQ_WRITE));
            else cmd = (roll == 1) ? REQ_WDATA : 3'($urandom_range(REQ_PROBE, REQ_WRITE));
         end else begin
            counted++;
            roll = $urandom_range(0, 99);
            if (seq_phase == PH_IDLE) begin
               if (!drive_found)
                  cmd = (roll < 60) ? REQ_PROBE : ((roll < 80) ? REQ_READ : REQ_WRITE);
               else
                  cmd = (roll < 15) ? REQ_PROBE : ((roll < 60) ? REQ_READ : REQ_WRITE);
            end else if (seq_phase == PH_WR_WORD) begin
               cmd = REQ_WDATA;
            end else begin
               // device side: status byte shaped by what the sequencer waits for
               cmd = REQ_RESP;
               case (seq_phase)
                  PH_ID_STAT: begin
                     if (roll < 10) data[7:0] = 8'h00;
                     else if (data[7:0] == 8'h00) data[0] = 1'b1;
                  end
                  PH_ID_BSY, PH_RW_BSY1, PH_RW_BSY2, PH_WR_FLUSH:
                     data[ST_BSY] = (roll < 35);
                  PH_ID_MID, PH_ID_HI: if (roll < 92) data[7:0] = 8'h00;
                  PH_DRQ: begin
                     if (roll < 8) begin
                        data[ST_ERR] = 1'b1;
                     end else begin
                        // a single sector transfer, early in the run
                        data[ST_ERR] = 1'b0;
                        data[ST_DRQ] = (roll >= 28) && (data_grants != 0) &&
                                       (sent_items < GRANT_BEFORE);
                        if (data[ST_DRQ]) data_grants--;
                     end
                  end
                  default: ;
               endcase
            end
         end
         send_item(cmd, lba, data, added);
      end
   endtask

   task automatic cmp_field(input string name, input logic [DATA_W-1:0] want,
                            input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      res_type      want;
      rsp_data_type got;
      got = rsp_data_type'(rsp_tdata);
      if (due_results.size() == 0) begin
         $error("unexpected result: kind %0d data %0h", rsp_tuser, rsp_tdata);
         errors++;
      end else begin
         want = due_results.pop_front();
         cmp_field("kind", 16'(want.kind), 16'(rsp_tuser));
         cmp_field("bus_write", 16'(want.bus_write), 16'(got.bus_write));
         cmp_field("bus_wide", 16'(want.bus_wide), 16'(got.bus_wide));
         cmp_field("port_offset", 16'(want.port_offset), 16'(got.port_offset));
         cmp_field("bus_data", want.bus_data, got.bus_data);
         cmp_field("ok", 16'(want.ok), 16'(got.ok));
         cmp_field("fail_cause", 16'(want.fail_cause), 16'(got.fail_cause));
         cmp_field("last", 16'(want.last), 16'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      int added;
      // no drive found yet, stray items, then a probe with no device and one not ata
      dir_table.push_back(dir_step(REQ_READ, 28'h0000000, 16'h0000, CHK_DONE,
                                   done_res(1'b0, CAUSE_NOT_PRESENT)));
      dir_table.push_back(dir_step(REQ_WRITE, 28'hFFFFFFF, 16'h0000, CHK_DONE,
                                   done_res(1'b0, CAUSE_NOT_PRESENT)));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'hFFFF, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(REQ_WDATA, 28'h0000000, 16'hFFFF, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(CMD_SPARE_FIRST, 28'h0000000, 16'h0000, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(CMD_SPARE_LAST, 28'hFFFFFFF, 16'hFFFF, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(REQ_PROBE, 28'h0000000, 16'h0000, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_READ, 28'hFFFFFFF, 16'hFFFF, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'hFFFF, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0000, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h00FF, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'hFF00, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'hFF00, CHK_DONE,
                                   done_res(1'b0, CAUSE_NO_DEVICE)));
      dir_table.push_back(dir_step(REQ_PROBE, 28'hFFFFFFF, 16'hFFFF, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h1234, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0000, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'hABCD, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0000, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0050, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_WDATA, 28'h0000000, 16'h5A5A, CHK_NOTHING, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0080, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0000, CHK_PREDICT, '0));
      dir_table.push_back(dir_step(REQ_RESP, 28'h0000000, 16'h0014, CHK_DONE,
                                   done_res(1'b0, CAUSE_NOT_ATA)));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_item(dir_table[i].cmd, dir_table[i].lba, dir_table[i].data, added);
         if (dir_table[i].check != CHK_PREDICT) begin
            repeat (added) void'(due_results.pop_back());
            if (dir_table[i].check == CHK_DONE) due_results.push_back(dir_table[i].res);
         end
      end

      run_phase(17, 47, 17'h1FFFF, 1'b0, ITEM_BUDGET / 4);
      run_phase(47, 17, 17'd1, 1'b1, ITEM_BUDGET / 2);
      run_phase(0, 0, 17'd0, 1'b0, ITEM_BUDGET * 3 / 4);
      run_phase(0, 0, 17'($urandom_range(2, 6)), 1'b1, ITEM_BUDGET);

      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/apsh_pkg.sv
rtl/apsh_ctrl.sv
rtl/apsh_rsp_queue.sv
rtl/ata_pio_sector_host_sequencer_top.sv
rtl/apsh_checker.sv
test/testbench.sv
